### rtl/core/tgd_pkg.sv
package tgd_pkg;

    localparam int SD_W      = 16;   // Q8.8 operands
    localparam int TQ_W      = 18;   // |t| in Q16, only values below 4.0 matter
    localparam int X_W       = 19;   // t*t/2 in Q16 over the core range
    localparam int P_W       = 31;   // Q30 series value, 0 .. 2^30
    localparam int V_W       = 11;   // taper distance 3.03 - |t| in Q16
    localparam int C_W       = 22;   // taper cubic coefficient
    localparam int VSQ_W     = 2 * V_W;
    localparam int W_W       = VSQ_W + C_W;   // Q48 taper value
    localparam int AV_W      = 26 + V_W;
    localparam int NUM_W     = 49;   // scaled density numerator
    localparam int QUO_W     = 25;   // density quotient width
    localparam int DENS_W    = 32;
    localparam int SERIES_TERMS = 10;
    localparam int RECIP_W   = 32;

    localparam logic [TQ_W-1:0] T300_Q16 = 18'd196608;
    localparam logic [TQ_W-1:0] T303_Q16 = 18'd198574;
    localparam logic [C_W-1:0]  A2_Q16   = 22'd2353993;
    localparam logic [25:0]     A3_Q16   = 26'd51502032;
    localparam logic [P_W-1:0]  ONE_Q30  = 31'h4000_0000;

    typedef enum logic [1:0] {
        REGION_CORE    = 2'd0,
        REGION_UPPER   = 2'd1,
        REGION_LOWER   = 2'd2,
        REGION_OUTSIDE = 2'd3
    } region_t;

    typedef struct packed {
        logic [15:0] midpoint;
        logic [15:0] age_mean;
        logic [15:0] std_dev;
    } tgd_in_t;

    typedef struct packed {
        logic [31:0] density;
        region_t     region;
    } tgd_out_t;

    // carried alongside the exp series
    typedef struct packed {
        logic [W_W-1:0]  w;
        logic [SD_W-1:0] sd;
        region_t         region;
    } tgd_side_t;

endpackage

### rtl/core/tgd_div.sv
// Restoring divider, one quotient bit per stage, elastic stall.
// in_rem must be below in_den.
module tgd_div #(
    parameter int Q_W    = 18,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [Q_W-1:0]    in_low,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [Q_W-1:0]    out_quo,
    output logic [DEN_W-1:0]  out_den,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_reg    [Q_W];
    logic              en       [Q_W];
    logic [DEN_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    sh_reg   [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    genvar i;
    for (i = 0; i < Q_W; i++) begin : g_stage
        logic              v_src;
        logic [DEN_W-1:0]  rem_src;
        logic [Q_W-1:0]    sh_src;
        logic [DEN_W-1:0]  den_src;
        logic [SIDE_W-1:0] side_src;
        logic              en_down;
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;
        logic [Q_W-1:0]    sh_next;

        if (i == 0) begin : g_first
            assign v_src    = in_valid;
            assign rem_src  = in_rem;
            assign sh_src   = in_low;
            assign den_src  = in_den;
            assign side_src = in_side;
        end else begin : g_chain
            assign v_src    = v_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign sh_src   = sh_reg[i-1];
            assign den_src  = den_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        if (i == Q_W - 1) begin : g_last
            assign en_down = out_ready;
        end else begin : g_mid
            assign en_down = en[i+1];
        end

        assign en[i]    = !v_reg[i] || en_down;
        assign trial    = {rem_src, sh_src[Q_W-1]};
        assign ge       = trial >= {1'b0, den_src};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_src}) : trial[DEN_W-1:0];
        assign sh_next  = {sh_src[Q_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en[i]) begin
                v_reg[i] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[i]) begin
                rem_reg[i]  <= rem_next;
                sh_reg[i]   <= sh_next;
                den_reg[i]  <= den_src;
                side_reg[i] <= side_src;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[Q_W-1];
    assign out_quo   = sh_reg[Q_W-1];
    assign out_den   = den_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

### rtl/core/tgd_exp.sv
// exp(-x) in Q30: ten-term Horner series of exp(-x/8), then three squarings.
// Each series term: multiply, reciprocal multiply, correct and subtract.
module tgd_exp #(
    parameter int SIDE_W = 62
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tgd_pkg::X_W-1:0]    in_x,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tgd_pkg::P_W-1:0]    out_e,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int TERMS   = tgd_pkg::SERIES_TERMS;
    localparam int SER_ST  = 3 * TERMS;
    localparam int STAGES  = SER_ST + 3;
    localparam int P_W     = tgd_pkg::P_W;
    localparam int X_W     = tgd_pkg::X_W;
    localparam int PA_W    = X_W + P_W;
    localparam int RW      = tgd_pkg::RECIP_W;
    localparam int QA_W    = P_W + RW;

    logic              v_reg    [STAGES];
    logic              en       [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];
    logic [X_W-1:0]    x_reg    [SER_ST];

    logic [PA_W-1:0]   pa_reg   [TERMS];
    logic [P_W-1:0]    a_reg    [TERMS];
    logic [QA_W-1:0]   qa_reg   [TERMS];
    logic [P_W-1:0]    p_reg    [TERMS];
    logic [P_W-1:0]    sq_reg   [3];

    genvar s, j, t;

    // valid, enable and sideband for every stage
    for (s = 0; s < STAGES; s++) begin : g_ctl
        logic              v_src;
        logic [SIDE_W-1:0] side_src;
        logic              en_down;

        if (s == 0) begin : g_first
            assign v_src    = in_valid;
            assign side_src = in_side;
        end else begin : g_chain
            assign v_src    = v_reg[s-1];
            assign side_src = side_reg[s-1];
        end

        if (s == STAGES - 1) begin : g_last
            assign en_down = out_ready;
        end else begin : g_mid
            assign en_down = en[s+1];
        end

        assign en[s] = !v_reg[s] || en_down;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en[s]) begin
                v_reg[s] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[s]) begin
                side_reg[s] <= side_src;
            end
        end

        if (s < SER_ST) begin : g_x
            logic [X_W-1:0] x_src;
            if (s == 0) begin : g_x0
                assign x_src = in_x;
            end else begin : g_xn
                assign x_src = x_reg[s-1];
            end
            always_ff @(posedge aclk) begin
                if (en[s]) begin
                    x_reg[s] <= x_src;
                end
            end
        end
    end

    for (j = 0; j < TERMS; j++) begin : g_term
        localparam int K = TERMS - j;
        localparam logic [RW-1:0]  RECIP = 32'hFFFF_FFFF / K;
        localparam logic [P_W-1:0] KW    = P_W'(K);

        logic [P_W-1:0]  p_src;
        logic [X_W-1:0]  x_src;
        logic [P_W-1:0]  q;
        logic [P_W-1:0]  r;
        logic [P_W-1:0]  term;
        logic [P_W-1:0]  p_next;

        if (j == 0) begin : g_p0
            assign p_src = tgd_pkg::ONE_Q30;
            assign x_src = in_x;
        end else begin : g_pn
            assign p_src = p_reg[j-1];
            assign x_src = x_reg[3*j-1];
        end

        assign q      = P_W'(qa_reg[j][QA_W-2:RW]);
        assign r      = a_reg[j] - P_W'(q * KW);
        assign term   = (r >= KW) ? P_W'(q + 1'b1) : q;
        assign p_next = (term >= tgd_pkg::ONE_Q30) ? '0 : P_W'(tgd_pkg::ONE_Q30 - term);

        always_ff @(posedge aclk) begin
            if (en[3*j]) begin
                pa_reg[j] <= PA_W'(x_src * p_src);
            end
            if (en[3*j+1]) begin
                a_reg[j]  <= pa_reg[j][PA_W-1:19];
                qa_reg[j] <= QA_W'(pa_reg[j][PA_W-1:19] * RECIP);
            end
            if (en[3*j+2]) begin
                p_reg[j]  <= p_next;
            end
        end
    end

    for (t = 0; t < 3; t++) begin : g_sq
        logic [P_W-1:0]     sq_src;
        logic [2*P_W-1:0]   prod;

        if (t == 0) begin : g_s0
            assign sq_src = p_reg[TERMS-1];
        end else begin : g_sn
            assign sq_src = sq_reg[t-1];
        end

        assign prod = (2*P_W)'(sq_src * sq_src) + ((2*P_W)'(1) << 29);

        always_ff @(posedge aclk) begin
            if (en[SER_ST+t]) begin
                sq_reg[t] <= prod[P_W+29:30];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[STAGES-1];
    assign out_e     = sq_reg[2];
    assign out_side  = side_reg[STAGES-1];

endmodule

### rtl/core/truncated_gaussian_density.sv
// Truncated Gaussian length density with a cubic tail. Each input transaction
// carries a length midpoint, a mean length and a standard deviation (unsigned
// Q8.8; a zero deviation is taken as 1/256). The block forms
// t = (midpoint - mean) / sd with |t| rounded to Q16 and returns one result
// transaction: exp(-t^2/2)/sd where |t| <= 3.00 (region 0), a cubic taper
// v^2 (a2 - a3 v)/sd with v = 3.03 - |t| where 3.00 < |t| <= 3.03 (region 1
// for t > 0, region 2 for t < 0), and zero beyond (region 3). The density is
// unsigned Q16.16. The block is a fully pipelined datapath that accepts one
// transaction every cycle unless m_ready holds it back. It contains the
// 18-stage |t| divider, the 33-stage exp unit (ten series terms of three
// stages each plus three squarings) and the 25-stage final divider by sd.
// Each stage holds its own valid bit and only stalls when it is full and the
// stage after it is blocked, so bubbles close up and the input keeps taking
// transactions while a finished result waits on m_ready.
module truncated_gaussian_density (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tgd_pkg::tgd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tgd_pkg::tgd_out_t m_data
);

    localparam int SD_W   = tgd_pkg::SD_W;
    localparam int TQ_W   = tgd_pkg::TQ_W;
    localparam int X_W    = tgd_pkg::X_W;
    localparam int P_W    = tgd_pkg::P_W;
    localparam int V_W    = tgd_pkg::V_W;
    localparam int C_W    = tgd_pkg::C_W;
    localparam int VSQ_W  = tgd_pkg::VSQ_W;
    localparam int W_W    = tgd_pkg::W_W;
    localparam int AV_W   = tgd_pkg::AV_W;
    localparam int NUM_W  = tgd_pkg::NUM_W;
    localparam int QUO_W  = tgd_pkg::QUO_W;
    localparam int SIDE_W = $bits(tgd_pkg::tgd_side_t);

    // ---------------- front: |mid - mean|, scaled numerator, range check
    logic            f_v_reg;
    logic            f_en;
    logic [SD_W-1:0] f_rem_reg;
    logic [TQ_W-1:0] f_low_reg;
    logic [SD_W-1:0] f_sd_reg;
    logic [1:0]      f_side_reg;     // {quotient too large, t positive}

    logic            f_pos;
    logic [SD_W-1:0] f_mag;
    logic [SD_W-1:0] f_sd;
    logic [31:0]     f_num;
    logic [SD_W-1:0] f_hi;
    logic            f_ovf;
    logic            d1_in_ready;

    assign f_sd  = (s_data.std_dev == '0) ? SD_W'(1) : s_data.std_dev;
    assign f_pos = s_data.midpoint > s_data.age_mean;
    assign f_mag = f_pos ? SD_W'(s_data.midpoint - s_data.age_mean)
                         : SD_W'(s_data.age_mean - s_data.midpoint);
    // |t| * 2^16 * sd, rounded: mag << 16 plus half of sd
    assign f_num = {f_mag, 16'h0000} + {17'h0, f_sd[SD_W-1:1]};
    // quotient fits in TQ_W bits only if the bits above TQ_W are below sd
    assign f_hi  = {2'b00, f_num[31:TQ_W]};
    assign f_ovf = f_hi >= f_sd;
    assign f_en  = !f_v_reg || d1_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg <= 1'b0;
        end else if (f_en) begin
            f_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_en) begin
            f_rem_reg  <= f_ovf ? '0 : f_hi;
            f_low_reg  <= f_num[TQ_W-1:0];
            f_sd_reg   <= f_sd;
            f_side_reg <= {f_ovf, f_pos};
        end
    end

    assign s_ready = f_en;

    // ---------------- |t| divider
    logic            d1_valid;
    logic            t1_en;
    logic [TQ_W-1:0] d1_tq;
    logic [SD_W-1:0] d1_sd;
    logic [1:0]      d1_side;

    tgd_div #(
        .Q_W    (TQ_W),
        .DEN_W  (SD_W),
        .SIDE_W (2)
    ) u_div_t (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_v_reg),
        .in_ready  (d1_in_ready),
        .in_rem    (f_rem_reg),
        .in_low    (f_low_reg),
        .in_den    (f_sd_reg),
        .in_side   (f_side_reg),
        .out_valid (d1_valid),
        .out_ready (t1_en),
        .out_quo   (d1_tq),
        .out_den   (d1_sd),
        .out_side  (d1_side)
    );

    // ---------------- T1: classify, tq^2, taper products
    logic              t1_v_reg;
    logic [2*TQ_W-1:0] t1_tqsq_reg;
    logic [AV_W-1:0]   t1_av_reg;
    logic [VSQ_W-1:0]  t1_vsq_reg;
    logic [SD_W-1:0]   t1_sd_reg;
    tgd_pkg::region_t  t1_region_reg;

    tgd_pkg::region_t  t1_region;
    logic [V_W-1:0]    t1_v;
    logic              t2_en;

    always_comb begin
        if (d1_side[1] || d1_tq > tgd_pkg::T303_Q16) begin
            t1_region = tgd_pkg::REGION_OUTSIDE;
        end else if (d1_tq <= tgd_pkg::T300_Q16) begin
            t1_region = tgd_pkg::REGION_CORE;
        end else if (d1_side[0]) begin
            t1_region = tgd_pkg::REGION_UPPER;
        end else begin
            t1_region = tgd_pkg::REGION_LOWER;
        end
    end

    // only meaningful inside the taper, where it is below 2^V_W
    assign t1_v  = V_W'(tgd_pkg::T303_Q16 - d1_tq);
    assign t1_en = !t1_v_reg || t2_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_v_reg <= 1'b0;
        end else if (t1_en) begin
            t1_v_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (t1_en) begin
            t1_tqsq_reg   <= (2*TQ_W)'(d1_tq * d1_tq);
            t1_av_reg     <= AV_W'(tgd_pkg::A3_Q16 * t1_v);
            t1_vsq_reg    <= VSQ_W'(t1_v * t1_v);
            t1_sd_reg     <= d1_sd;
            t1_region_reg <= t1_region;
        end
    end

    // ---------------- T2: x = t^2/2, taper coefficient
    logic              t2_v_reg;
    logic [X_W-1:0]    t2_x_reg;
    logic [C_W-1:0]    t2_c_reg;
    logic [VSQ_W-1:0]  t2_vsq_reg;
    logic [SD_W-1:0]   t2_sd_reg;
    tgd_pkg::region_t  t2_region_reg;

    logic [2*TQ_W:0]   t2_sum;
    logic              t3_en;

    assign t2_sum = {1'b0, t1_tqsq_reg} + (2*TQ_W+1)'(1 << 16);
    assign t2_en  = !t2_v_reg || t3_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t2_v_reg <= 1'b0;
        end else if (t2_en) begin
            t2_v_reg <= t1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (t2_en) begin
            t2_x_reg      <= t2_sum[X_W+16:17];
            t2_c_reg      <= tgd_pkg::A2_Q16 - C_W'(t1_av_reg[AV_W-1:16]);
            t2_vsq_reg    <= t1_vsq_reg;
            t2_sd_reg     <= t1_sd_reg;
            t2_region_reg <= t1_region_reg;
        end
    end

    // ---------------- T3: taper value w = v^2 c (Q48)
    logic              t3_v_reg;
    logic [X_W-1:0]    t3_x_reg;
    tgd_pkg::tgd_side_t t3_side_reg;
    logic              ex_in_ready;

    assign t3_en = !t3_v_reg || ex_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t3_v_reg <= 1'b0;
        end else if (t3_en) begin
            t3_v_reg <= t2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (t3_en) begin
            t3_x_reg           <= t2_x_reg;
            t3_side_reg.w      <= W_W'(t2_vsq_reg * t2_c_reg);
            t3_side_reg.sd     <= t2_sd_reg;
            t3_side_reg.region <= t2_region_reg;
        end
    end

    // ---------------- exp unit
    logic               ex_valid;
    logic               t4_en;
    logic [P_W-1:0]     ex_e;
    logic [SIDE_W-1:0]  ex_side_bits;
    tgd_pkg::tgd_side_t ex_side;

    tgd_exp #(
        .SIDE_W (SIDE_W)
    ) u_exp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (t3_v_reg),
        .in_ready  (ex_in_ready),
        .in_x      (t3_x_reg),
        .in_side   (t3_side_reg),
        .out_valid (ex_valid),
        .out_ready (t4_en),
        .out_e     (ex_e),
        .out_side  (ex_side_bits)
    );

    assign ex_side = tgd_pkg::tgd_side_t'(ex_side_bits);

    // ---------------- T4: common numerator over sd * 2^24
    // core: (e + 32 sd) / (64 sd) is the same quotient as
    // ((e << 18) + (sd << 23)) / (sd << 24)
    logic             t4_v_reg;
    logic [QUO_W-1:0] t4_nh_reg;
    logic [SD_W-1:0]  t4_sd_reg;
    logic [1:0]       t4_region_reg;

    logic [NUM_W-1:0] t4_half;
    logic [NUM_W-1:0] t4_num;
    logic             d2_in_ready;

    assign t4_half = NUM_W'({ex_side.sd, 23'h0});

    always_comb begin
        case (ex_side.region)
            tgd_pkg::REGION_CORE: begin
                t4_num = NUM_W'({ex_e, 18'h0}) + t4_half;
            end
            tgd_pkg::REGION_UPPER, tgd_pkg::REGION_LOWER: begin
                t4_num = NUM_W'(ex_side.w) + t4_half;
            end
            default: begin
                t4_num = '0;
            end
        endcase
    end

    assign t4_en = !t4_v_reg || d2_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t4_v_reg <= 1'b0;
        end else if (t4_en) begin
            t4_v_reg <= ex_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (t4_en) begin
            t4_nh_reg     <= t4_num[NUM_W-1:24];
            t4_sd_reg     <= ex_side.sd;
            t4_region_reg <= ex_side.region;
        end
    end

    // ---------------- final divider by sd; its last stage is the output register
    logic [QUO_W-1:0] d2_quo;
    logic [SD_W-1:0]  d2_sd;
    logic [1:0]       d2_side;

    tgd_div #(
        .Q_W    (QUO_W),
        .DEN_W  (SD_W),
        .SIDE_W (2)
    ) u_div_d (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (t4_v_reg),
        .in_ready  (d2_in_ready),
        .in_rem    ('0),
        .in_low    (t4_nh_reg),
        .in_den    (t4_sd_reg),
        .in_side   (t4_region_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_quo   (d2_quo),
        .out_den   (d2_sd),
        .out_side  (d2_side)
    );

    // quotient is below 2^25, the Q16.16 cap is never reached
    assign m_data.density = (d2_sd != '0) ? tgd_pkg::DENS_W'(d2_quo) : '1;
    assign m_data.region  = tgd_pkg::region_t'(d2_side);

`ifndef SYNTHESIS
    // outside the taper nothing is left
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.region == tgd_pkg::REGION_OUTSIDE |-> m_data.density == '0)
        else $error("outside region with nonzero density");

    // core peak is 1/sd with sd >= 1/256, i.e. at most 256.0
    a_core_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.region == tgd_pkg::REGION_CORE |-> m_data.density <= 32'h0100_0000)
        else $error("core density above peak");

    // taper density stays below 512.0
    a_taper_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.region == tgd_pkg::REGION_UPPER ||
                    m_data.region == tgd_pkg::REGION_LOWER) |-> m_data.density[31:25] == '0)
        else $error("taper density out of range");

    // an empty output stage lets the whole pipe advance
    a_no_deadlock: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output stage");
`endif

endmodule

### sim/truncated_gaussian_density_tb.sv
module truncated_gaussian_density_tb;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    tgd_pkg::tgd_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    tgd_pkg::tgd_out_t m_data;

    truncated_gaussian_density dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // pending input transactions, and expected results in arrival order
    tgd_pkg::tgd_in_t  pending_q[$];
    tgd_pkg::tgd_out_t density_q[$];
    int       n_errors  = 0;
    bit       stim_done = 0;
    bit       quiet     = 0;   // no idling in the tail of the run
    bit       hold      = 0;   // long receiver hold-off in progress
    bit       in_taken  = 0;   // input transaction accepted at the last rising edge

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    // Predicted density for one item, fixed point throughout.
    function automatic tgd_pkg::tgd_out_t predict_density(tgd_pkg::tgd_in_t it);
        logic [63:0]       sd, mag, tq, x, p, term, v, c, w, dens;
        bit                positive;
        tgd_pkg::tgd_out_t r;
        sd = {48'd0, it.std_dev};
        if (sd == 0) sd = 1;   // zero deviation reads as 1/256
        positive = it.midpoint > it.age_mean;
        mag = positive ? 64'(it.midpoint - it.age_mean)
                       : 64'(it.age_mean - it.midpoint);
        tq = ((mag << 16) + (sd >> 1)) / sd;
        if (tq <= 64'(tgd_pkg::T300_Q16)) begin
            x = (tq * tq + 64'd65536) >> 17;
            // exp(-x/8) by nested series, then squared three times up to exp(-x)
            p = 64'd1 << 30;
            for (int k = tgd_pkg::SERIES_TERMS; k >= 1; k--) begin
                term = ((x * p) >> 19) / k;
                p = (term >= (64'd1 << 30)) ? 64'd0 : ((64'd1 << 30) - term);
            end
            for (int i = 0; i < 3; i++) p = (p * p + (64'd1 << 29)) >> 30;
            dens = (p + 32 * sd) / (64 * sd);
            r.region = tgd_pkg::REGION_CORE;
        end else if (tq <= 64'(tgd_pkg::T303_Q16)) begin
            v = 64'(tgd_pkg::T303_Q16) - tq;
            c = 64'(tgd_pkg::A2_Q16) - ((64'(tgd_pkg::A3_Q16) * v) >> 16);
            w = v * v * c;
            dens = (w + (sd << 23)) / (sd << 24);
            r.region = positive ? tgd_pkg::REGION_UPPER : tgd_pkg::REGION_LOWER;
        end else begin
            dens = 0;
            r.region = tgd_pkg::REGION_OUTSIDE;
        end
        r.density = (dens > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dens[31:0];
        return r;
    endfunction

    // Mean plus or minus an offset of t*sd, t given in Q16, used to aim at the taper.
    function automatic tgd_pkg::tgd_in_t aim_item(int mean, int sd, int tq, bit up);
        tgd_pkg::tgd_in_t it;
        longint           off;
        off = (longint'(tq) * sd + 32768) >>> 16;
        it.std_dev = sd[15:0];
        it.age_mean = mean[15:0];
        if (up) it.midpoint = 16'(longint'(mean) + off);
        else    it.midpoint = 16'(longint'(mean) - off);
        return it;
    endfunction

    // Input acceptance is seen at the rising edge, where the prediction is queued.
    always @(posedge aclk) begin
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            density_q.push_back(predict_density(s_data));
        end
    end

    // Driver: valid held until accepted, random gaps in bursts.
    int gap_cnt = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            // slot free: choose next item or a gap
            if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                s_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                gap_cnt <= $urandom_range(1, 19) - 1;
                s_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                s_data  <= pending_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so the pipeline fills and stalls the input
    initial begin
        @(posedge aresetn);
        repeat (20) @(posedge aclk);
        hold = 1'b1;
        repeat (300) @(posedge aclk);
        hold = 1'b0;
    end

    // Receiver stall pattern
    int stall_cnt = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold) begin
            m_ready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_ready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_cnt <= $urandom_range(1, 19) - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    tgd_pkg::tgd_out_t want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (density_q.size() == 0) begin
                $display("%0t: unexpected result density=%h region=%0d",
                         $time, m_data.density, m_data.region);
                n_errors++;
            end else begin
                want = density_q.pop_front();
                if (m_data.density !== want.density) begin
                    $display("%0t: density expected %h actual %h",
                             $time, want.density, m_data.density);
                    n_errors++;
                end
                if (m_data.region !== want.region) begin
                    $display("%0t: region expected %0d actual %0d",
                             $time, want.region, m_data.region);
                    n_errors++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        tgd_pkg::tgd_in_t it;
        int               mean, sd, tq;
        int               waited;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;

        // directed: field extremes, exact mean, zero deviation, region edges
        pending_q.push_back('{16'h0000, 16'h0000, 16'h0000});
        pending_q.push_back('{16'hFFFF, 16'hFFFF, 16'h0001});
        pending_q.push_back('{16'hFFFF, 16'h0000, 16'hFFFF});
        pending_q.push_back('{16'h0000, 16'hFFFF, 16'hFFFF});
        pending_q.push_back('{16'hFFFF, 16'h0000, 16'h0001});
        pending_q.push_back('{16'h1234, 16'h1234, 16'h0000});
        pending_q.push_back('{16'h0300, 16'h0000, 16'h0100});  // t = 3.00
        pending_q.push_back('{16'h0000, 16'h0300, 16'h0100});  // t = -3.00
        pending_q.push_back('{16'h0301, 16'h0000, 16'h0100});  // just past 3
        pending_q.push_back('{16'h0000, 16'h0301, 16'h0100});
        pending_q.push_back('{16'h0308, 16'h0000, 16'h0100});  // beyond 3.03
        pending_q.push_back('{16'h8000, 16'h7FFF, 16'h0001});
        pending_q.push_back('{16'h5555, 16'hAAAA, 16'h8000});
        pending_q.push_back('{16'hAAAA, 16'h5555, 16'h7FFF});
        pending_q.push_back(aim_item(16'h8000, 16'h4000, 198574, 1'b1));
        pending_q.push_back(aim_item(16'h8000, 16'h4000, 198574, 1'b0));
        pending_q.push_back(aim_item(16'h8000, 16'h4000, 197000, 1'b1));

        // random: mostly near the curve, some taper aims, some raw noise
        for (int n = 0; n < 700; n++) begin
            case ($urandom_range(0, 3))
                0: begin
                    it.midpoint = 16'($urandom);
                    it.age_mean = 16'($urandom);
                    it.std_dev  = 16'($urandom);
                end
                1: begin
                    sd   = $urandom_range(1, 4096);
                    mean = $urandom_range(20000, 45000);
                    tq   = $urandom_range(196000, 199500);
                    it   = aim_item(mean, sd, tq, 1'($urandom_range(0, 1)));
                end
                default: begin
                    sd   = $urandom_range(1, 65535);
                    mean = $urandom;
                    it.std_dev  = sd[15:0];
                    it.age_mean = mean[15:0];
                    it.midpoint = 16'(mean + $signed($urandom_range(0, 2 * sd))
                                      - sd);
                end
            endcase
            pending_q.push_back(it);
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        wait (pending_q.size() < 100);
        quiet = 1'b1;
        wait (stim_done);
        waited = 0;
        while (density_q.size() > 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (100) @(posedge aclk);
        if (n_errors == 0 && density_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
